### rtl/core/mfr_pkg.sv
// Package for the meter frame receiver.
// Holds the result record, status codes and register indexes shared by all modules.
// No dependencies.
package mfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 9;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hDD;
    localparam logic [BYTE_W-1:0] FUNC_RESET = 8'h31;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_FUNCTION = 1'b1;

    localparam logic [INDEX_W-1:0] FUNC_POS  = 9'd2;
    localparam logic [INDEX_W-1:0] COUNT_POS = 9'd4;
    localparam logic [INDEX_W-1:0] LEN_EXTRA = 9'd7;

    typedef enum logic [1:0] {
        STATUS_BUSY      = 2'd0,
        STATUS_GOOD      = 2'd1,
        STATUS_CSUM_BAD  = 2'd2,
        STATUS_FUNC_BAD  = 2'd3
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  frame_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               last;
        status_t            status;
    } result_t;

endpackage

### rtl/core/mfr_in_stage.sv
// Input register of the meter frame receiver.
// Holds one received byte until the parser consumes it; uses mfr_pkg.
module mfr_in_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mfr_pkg::BYTE_W-1:0]   s_byte,
    input  logic                         consume,
    output logic                         item_valid,
    output logic [mfr_pkg::BYTE_W-1:0]   item_byte
);
    import mfr_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_tready   = !valid_reg || consume;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (consume)
        begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_byte;
        end
    end

endmodule

### rtl/core/mfr_parser.sv
// Frame parser of the meter frame receiver: configuration registers, frame state
// and the per-byte decision logic. Uses mfr_pkg.
module mfr_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mfr_pkg::BYTE_W-1:0]      cfg_wdata,
    input  logic                            item_valid,
    input  logic [mfr_pkg::BYTE_W-1:0]      item_byte,
    input  logic                            step,
    output logic                            res_valid,
    output mfr_pkg::result_t                res
);
    import mfr_pkg::*;

    logic [BYTE_W-1:0]  sync_value_reg;
    logic [BYTE_W-1:0]  expected_function_reg;

    logic               in_frame_reg;
    logic               in_frame_next;
    logic [INDEX_W-1:0] position_reg;
    logic [INDEX_W-1:0] position_next;
    logic [INDEX_W-1:0] frame_length_reg;
    logic [INDEX_W-1:0] frame_length_next;
    logic [BYTE_W-1:0]  running_sum_reg;
    logic [BYTE_W-1:0]  running_sum_next;

    logic               past_count;
    logic               at_csum;
    logic               at_end;

    assign past_count = position_reg > COUNT_POS;
    assign at_csum    = past_count && (position_reg == frame_length_reg - 9'd2);
    assign at_end     = past_count && (position_reg == frame_length_reg - 9'd1);

    always_comb
    begin
        in_frame_next     = in_frame_reg;
        position_next     = position_reg;
        frame_length_next = frame_length_reg;
        running_sum_next  = running_sum_reg;
        res_valid         = 1'b0;
        res.frame_byte    = item_byte;
        res.byte_index    = position_reg;
        res.last          = 1'b0;
        res.status        = STATUS_BUSY;

        if (!in_frame_reg)
        begin
            res.byte_index = '0;
            if (item_byte == sync_value_reg)
            begin
                res_valid         = item_valid;
                in_frame_next     = 1'b1;
                position_next     = 9'd1;
                frame_length_next = '0;
                running_sum_next  = item_byte;
            end
        end
        else
        begin
            res_valid = item_valid;
            if (position_reg == FUNC_POS && item_byte != expected_function_reg)
            begin
                res.last   = 1'b1;
                res.status = STATUS_FUNC_BAD;
            end
            else if (at_csum && running_sum_reg != item_byte)
            begin
                res.last   = 1'b1;
                res.status = STATUS_CSUM_BAD;
            end
            else if (!at_csum && at_end)
            begin
                res.last   = 1'b1;
                res.status = STATUS_GOOD;
            end
            else
            begin
                position_next = position_reg + 9'd1;
                if (!at_csum)
                begin
                    running_sum_next = running_sum_reg + item_byte;
                end
                if (position_reg == COUNT_POS)
                begin
                    frame_length_next = {1'b0, item_byte} + LEN_EXTRA;
                end
            end

            if (res.last)
            begin
                in_frame_next     = 1'b0;
                position_next     = '0;
                frame_length_next = '0;
                running_sum_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg        <= SYNC_RESET;
            expected_function_reg <= FUNC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SYNC_VALUE:        sync_value_reg        <= cfg_wdata;
                REG_EXPECTED_FUNCTION: expected_function_reg <= cfg_wdata;
                default:               sync_value_reg        <= sync_value_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg     <= 1'b0;
            position_reg     <= '0;
            frame_length_reg <= '0;
            running_sum_reg  <= '0;
        end
        else if (step)
        begin
            in_frame_reg     <= in_frame_next;
            position_reg     <= position_next;
            frame_length_reg <= frame_length_next;
            running_sum_reg  <= running_sum_next;
        end
    end

endmodule

### rtl/core/mfr_out_stage.sv
// Output register of the meter frame receiver.
// Holds one result transaction until the downstream side takes it; uses mfr_pkg.
module mfr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mfr_pkg::result_t  load_res,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output mfr_pkg::result_t  m_res
);
    import mfr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (m_tready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

endmodule

### rtl/core/meter_frame_receiver.sv
// Meter frame receiver, top level: input register, frame parser and output register.
// Depends on mfr_pkg, mfr_in_stage, mfr_parser and mfr_out_stage.
//
// The receiver takes one byte per cycle and answers each with at most one result
// transaction via the input and output registers, so it streams one byte per clock for as
// long as the output side keeps taking results. Bytes are dropped until one equals
// sync_value; from then on every byte is passed out with its frame index. A frame is
// closed with tlast and a status in tuser when the function code at index 2 is wrong,
// the checksum byte does not match the 8-bit sum of the earlier bytes, or the final
// byte (index count + 6, the count sitting at index 4) arrives. Configuration writes
// take effect at once and belong in idle periods between frames.
module meter_frame_receiver (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [7:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,     // [7:0] frame_byte, [16:8] byte_index, [23:17] zero
    output logic         m_tlast,
    output logic [1:0]   m_tuser      // [1:0] status
);
    import mfr_pkg::*;

    logic              item_valid;
    logic [BYTE_W-1:0] item_byte;
    logic              consume;
    logic              res_valid;
    result_t           res;
    logic              out_free;
    result_t           out_res;

    assign consume = item_valid && (!res_valid || out_free);

    mfr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_byte     (s_tdata),
        .consume    (consume),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    mfr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .step       (consume),
        .res_valid  (res_valid),
        .res        (res)
    );

    mfr_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (consume && res_valid),
        .load_res (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (out_res)
    );

    assign m_tdata = {7'd0, out_res.byte_index, out_res.frame_byte};
    assign m_tlast = out_res.last;
    assign m_tuser = out_res.status;

endmodule

### bench/tb_top.sv
// Self-checking testbench for meter_frame_receiver: directed, longest-frame, register and random frame tests.
// A behavioral frame parser predicts every result transaction, which is checked field by field.
// Depends on mfr_pkg and the meter_frame_receiver RTL.
module tb_top;

    import mfr_pkg::*;

    localparam int unsigned IDLE_LIMIT = 2000;

    typedef enum int unsigned {
        SHAPE_GOOD,
        SHAPE_BAD_SUM,
        SHAPE_BAD_FUNC
    } frame_shape_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [0:0]   cfg_index;
    logic [7:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;
    logic         m_tlast;
    logic [1:0]   m_tuser;

    logic [7:0]   sync_reg = SYNC_RESET;
    logic [7:0]   func_reg = FUNC_RESET;
    logic         framing = 1'b0;
    logic [8:0]   rx_pos = '0;
    logic [8:0]   rx_len = '0;
    logic [7:0]   rx_sum = '0;

    result_t      expected_results[$];
    result_t      want;
    int unsigned  results_made = 0;
    int unsigned  err_count = 0;
    int unsigned  idle_cycles = 0;
    bit           steady = 1'b0;

    meter_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void return_to_hunt();
        framing = 1'b0;
        rx_pos = '0;
        rx_len = '0;
        rx_sum = '0;
    endfunction

    function automatic void parse_rx_byte(input logic [7:0] b);
        result_t r;
        logic [8:0] idx;
        if (!framing)
        begin
            if (b != sync_reg)
                return;
            framing = 1'b1;
            rx_pos = 9'd1;
            rx_len = '0;
            rx_sum = b;
            r.frame_byte = b;
            r.byte_index = '0;
            r.last = 1'b0;
            r.status = STATUS_BUSY;
            expected_results.push_back(r);
            results_made++;
            return;
        end
        idx = rx_pos;
        r.frame_byte = b;
        r.byte_index = idx;
        r.last = 1'b0;
        r.status = STATUS_BUSY;
        if (idx == FUNC_POS && b != func_reg)
        begin
            r.last = 1'b1;
            r.status = STATUS_FUNC_BAD;
            return_to_hunt();
        end
        else
        begin
            if (idx == COUNT_POS)
                rx_len = {1'b0, b} + LEN_EXTRA;
            if (idx > COUNT_POS && idx == rx_len - 9'd2)
            begin
                if (rx_sum != b)
                begin
                    r.last = 1'b1;
                    r.status = STATUS_CSUM_BAD;
                    return_to_hunt();
                end
                else
                    rx_pos = idx + 9'd1;
            end
            else if (idx > COUNT_POS && idx == rx_len - 9'd1)
            begin
                r.last = 1'b1;
                r.status = STATUS_GOOD;
                return_to_hunt();
            end
            else
            begin
                rx_sum = rx_sum + b;
                rx_pos = idx + 9'd1;
            end
        end
        expected_results.push_back(r);
        results_made++;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                parse_rx_byte(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction: frame_byte %0d, byte_index %0d",
                           m_tdata[7:0], m_tdata[16:8]);
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[7:0] !== want.frame_byte)
                    begin
                        $error("frame_byte: expected %0d, got %0d", want.frame_byte, m_tdata[7:0]);
                        err_count++;
                    end
                    if (m_tdata[16:8] !== want.byte_index)
                    begin
                        $error("byte_index: expected %0d, got %0d", want.byte_index, m_tdata[16:8]);
                        err_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        err_count++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        err_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_SYNC_VALUE)
                    sync_reg = cfg_wdata;
                else if (cfg_index == REG_EXPECTED_FUNCTION)
                    func_reg = cfg_wdata;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 99)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin
        int unsigned stall;
        m_tready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0 && !steady)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = steady ? 0 : pick_gap();
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'($urandom_range(0, 255));
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_noise(input int unsigned n);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom_range(0, 255));
            while (b == sync_reg)
                b = 8'($urandom_range(0, 255));
            send_byte(b);
        end
    endtask

    task automatic send_frame(input int unsigned count, input frame_shape_t shape, input int fill);
        logic [7:0] sum;
        logic [7:0] b;
        int unsigned n;
        sum = '0;
        for (n = 0; n < count + 7; n++)
        begin
            if (fill < 0)
                b = 8'($urandom_range(0, 255));
            else
                b = fill[7:0];
            if (n == 0)
                b = sync_reg;
            else if (n == FUNC_POS)
            begin
                b = func_reg;
                if (shape == SHAPE_BAD_FUNC)
                begin
                    b = 8'($urandom_range(1, 255));
                    b = b ^ func_reg;
                end
            end
            else if (n == COUNT_POS)
                b = count[7:0];
            else if (n == count + 5)
            begin
                b = sum;
                if (shape == SHAPE_BAD_SUM)
                begin
                    b = 8'($urandom_range(1, 255));
                    b = b ^ sum;
                end
            end
            sum = sum + b;
            send_byte(b);
            if (shape == SHAPE_BAD_FUNC && n == FUNC_POS)
                break;
            if (shape == SHAPE_BAD_SUM && n == count + 5)
                break;
        end
    endtask

    task automatic close_open_frame();
        while (framing)
        begin
            if (rx_pos == FUNC_POS)
                send_byte(func_reg ^ 8'h01);
            else if (rx_pos == COUNT_POS)
                send_byte(8'h00);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
        close_open_frame();
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int unsigned pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 90)
            return $urandom_range(0, 12);
        if (r < 98)
            return $urandom_range(13, 60);
        return $urandom_range(200, 255);
    endfunction

    task automatic test_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(0, SHAPE_GOOD, 'hDD);
        send_frame(0, SHAPE_GOOD, 'hFF);
        send_frame(0, SHAPE_BAD_FUNC, 'h00);
        send_frame(0, SHAPE_BAD_SUM, 'hFF);
    endtask

    task automatic test_longest_frame();
        steady = 1'b1;
        send_frame(255, SHAPE_GOOD, -1);
        steady = 1'b0;
    endtask

    task automatic test_registers();
        logic [7:0] sync_vals[4];
        logic [7:0] func_vals[4];
        int unsigned k;
        sync_vals = '{8'h00, 8'hFF, 8'h00, 8'hFF};
        func_vals = '{8'hFF, 8'h00, 8'h00, 8'hFF};
        for (k = 0; k < 4; k++)
        begin
            write_reg(REG_SYNC_VALUE, sync_vals[k]);
            write_reg(REG_EXPECTED_FUNCTION, func_vals[k]);
            send_noise(3);
            send_frame($urandom_range(0, 5), SHAPE_GOOD, -1);
            send_frame($urandom_range(0, 5), SHAPE_BAD_FUNC, -1);
            send_frame($urandom_range(0, 5), SHAPE_BAD_SUM, -1);
        end
    endtask

    task automatic test_random();
        int unsigned phase;
        int unsigned mark;
        int unsigned r;
        int unsigned k;
        for (phase = 0; phase < 4; phase++)
        begin
            if (phase == 0)
            begin
                write_reg(REG_SYNC_VALUE, SYNC_RESET);
                write_reg(REG_EXPECTED_FUNCTION, FUNC_RESET);
            end
            else
            begin
                write_reg(REG_SYNC_VALUE, 8'($urandom_range(0, 255)));
                write_reg(REG_EXPECTED_FUNCTION, 8'($urandom_range(0, 255)));
            end
            steady = (phase == 2);
            mark = results_made;
            while (results_made - mark < 75)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_frame(pick_count(), SHAPE_GOOD, -1);
                else if (r < 80)
                    send_frame(pick_count(), SHAPE_BAD_SUM, -1);
                else if (r < 87)
                    send_frame(pick_count(), SHAPE_BAD_FUNC, -1);
                else if (r < 94)
                    send_noise($urandom_range(1, 6));
                else if (r < 98)
                begin
                    send_byte(sync_reg);
                    for (k = $urandom_range(1, 10); k > 0; k--)
                        send_byte(8'($urandom_range(0, 255)));
                end
                else
                    wait_drained();
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_longest_frame();
        test_registers();
        test_random();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (err_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
